// ===== src/dtmf_pkg.sv =====
// ----------------------------------------------------------------------------
// dtmf_pkg
// Shared constants and types of the DTMF tone generator: loop length, phase
// widths, request and register codes, and the tick request carried between
// the request front end and the sample back end.
// ----------------------------------------------------------------------------
package dtmf_pkg;

	localparam int LOOP_SAMPLES = 8000;

	localparam int PH_W = $clog2(LOOP_SAMPLES);
	localparam int R_W  = $clog2(LOOP_SAMPLES + 1);
	localparam int Q_W  = PH_W + 2;

	localparam int NSTEP     = 5;
	localparam int SINE_LAT  = 7 + 2 * NSTEP;
	localparam int PIPE_LAT  = SINE_LAT + 3;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	localparam int AMP_W     = 15;
	localparam int CFG_IDX_W = 2;

	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_START = 2'd1;
	localparam logic [1:0] REQ_STOP  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_LAW     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_AMP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COL_AMP = 2'd2;

	localparam logic [AMP_W-1:0] ROW_AMP_RESET = 15'd8224;
	localparam logic [AMP_W-1:0] COL_AMP_RESET = 15'd5177;

	typedef struct packed {
		logic            active;
		logic [PH_W-1:0] row_phase;
		logic [PH_W-1:0] col_phase;
	} job_t;

	typedef struct packed {
		logic       hit;
		logic [3:0] idx;
	} key_dec_t;

endpackage

// ===== src/dtmf_fifo.sv =====
// ----------------------------------------------------------------------------
// dtmf_fifo
// Short queue of tick requests between the request front end and the sample
// back end.
// ----------------------------------------------------------------------------
module dtmf_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  dtmf_pkg::job_t  push_data,
	output logic            full,
	input  logic            pop,
	output logic            valid,
	output dtmf_pkg::job_t  pop_data
);
	import dtmf_pkg::*;

	job_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW:0]   wr_ptr_q;
	logic [QUEUE_AW:0]   rd_ptr_q;

	assign valid    = (wr_ptr_q != rd_ptr_q);
	assign full     = (wr_ptr_q[QUEUE_AW-1:0] == rd_ptr_q[QUEUE_AW-1:0]) &&
	                  (wr_ptr_q[QUEUE_AW] != rd_ptr_q[QUEUE_AW]);
	assign pop_data = mem_q[rd_ptr_q[QUEUE_AW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q[QUEUE_AW-1:0]] <= push_data;
		end
	end

endmodule

// ===== src/dtmf_front.sv =====
// ----------------------------------------------------------------------------
// dtmf_front
// Request front end: decodes start, stop and tick requests, keeps the tone
// state and both phase counters, and queues one entry per tick.
// ----------------------------------------------------------------------------
module dtmf_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  logic [1:0]      req_type,
	input  logic [7:0]      key_char,
	input  logic            q_full,
	output logic            q_push,
	output dtmf_pkg::job_t  q_data
);
	import dtmf_pkg::*;

	function automatic key_dec_t key_decode(input logic [7:0] c);
		key_dec_t d;
		d.hit = 1'b1;
		case (c)
			8'h31:        d.idx = 4'd0;
			8'h32:        d.idx = 4'd1;
			8'h33:        d.idx = 4'd2;
			8'h41, 8'h61: d.idx = 4'd3;
			8'h34:        d.idx = 4'd4;
			8'h35:        d.idx = 4'd5;
			8'h36:        d.idx = 4'd6;
			8'h42, 8'h62: d.idx = 4'd7;
			8'h37:        d.idx = 4'd8;
			8'h38:        d.idx = 4'd9;
			8'h39:        d.idx = 4'd10;
			8'h43, 8'h63: d.idx = 4'd11;
			8'h2A:        d.idx = 4'd12;
			8'h30:        d.idx = 4'd13;
			8'h23:        d.idx = 4'd14;
			8'h44, 8'h64: d.idx = 4'd15;
			default: begin
				d.hit = 1'b0;
				d.idx = 4'd0;
			end
		endcase
		return d;
	endfunction

	function automatic logic [PH_W-1:0] row_hz(input logic [1:0] r);
		case (r)
			2'd0:    return PH_W'(697);
			2'd1:    return PH_W'(770);
			2'd2:    return PH_W'(852);
			default: return PH_W'(941);
		endcase
	endfunction

	function automatic logic [PH_W-1:0] col_hz(input logic [1:0] c);
		case (c)
			2'd0:    return PH_W'(1209);
			2'd1:    return PH_W'(1336);
			2'd2:    return PH_W'(1477);
			default: return PH_W'(1633);
		endcase
	endfunction

	function automatic logic [PH_W-1:0] wrap_add(input logic [PH_W-1:0] p,
	                                             input logic [PH_W-1:0] step);
		logic [PH_W:0] sum;
		sum = {1'b0, p} + {1'b0, step};
		if (sum >= (PH_W + 1)'(LOOP_SAMPLES)) begin
			sum = sum - (PH_W + 1)'(LOOP_SAMPLES);
		end
		return sum[PH_W-1:0];
	endfunction

	logic            active_q;
	logic [3:0]      key_q;
	logic [PH_W-1:0] row_phase_q;
	logic [PH_W-1:0] col_phase_q;

	logic            req_acc;
	key_dec_t        dec;
	logic [PH_W-1:0] row_next;
	logic [PH_W-1:0] col_next;

	assign req_ready = !q_full;
	assign req_acc   = req_valid && req_ready;
	assign dec       = key_decode(key_char);
	assign row_next  = wrap_add(row_phase_q, row_hz(key_q[3:2]));
	assign col_next  = wrap_add(col_phase_q, col_hz(key_q[1:0]));

	assign q_push           = req_acc && (req_type == REQ_TICK);
	assign q_data.active    = active_q;
	assign q_data.row_phase = row_phase_q;
	assign q_data.col_phase = col_phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			key_q       <= 4'd0;
			row_phase_q <= '0;
			col_phase_q <= '0;
		end else if (req_acc) begin
			case (req_type)
				REQ_START: begin
					if (dec.hit) begin
						key_q    <= dec.idx;
						active_q <= 1'b1;
					end
					row_phase_q <= '0;
					col_phase_q <= '0;
				end
				REQ_STOP: begin
					active_q <= 1'b0;
				end
				REQ_TICK: begin
					if (active_q) begin
						row_phase_q <= row_next;
						col_phase_q <= col_next;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== src/dtmf_sine.sv =====
// ----------------------------------------------------------------------------
// dtmf_sine
// Pipelined Q1.15 sine of a phase in 0..LOOP_SAMPLES-1: quadrant fold, Q2.30
// angle, five Horner steps of the odd series, rounding to Q1.15.
// ----------------------------------------------------------------------------
module dtmf_sine (
	input  logic                      clk,
	input  logic                      en,
	input  logic [dtmf_pkg::PH_W-1:0] phase,
	output logic signed [15:0]        sine
);
	import dtmf_pkg::*;

	localparam int X_W    = 31;
	localparam int T_W    = 31;
	localparam int X2_W   = 32;
	localparam int Y_W    = 2 * R_W;
	localparam int LP_W   = 2 * Y_W + 1;
	localparam int LRCP_W = Y_W + 1;
	localparam int LSH    = Y_W + $clog2(LOOP_SAMPLES);

	localparam logic [63:0]       HALF_PI_Q30 = 64'd1686629713;
	localparam logic [X_W-1:0]    HQ   = X_W'(HALF_PI_Q30 / 64'(LOOP_SAMPLES));
	localparam logic [R_W-1:0]    HR   = R_W'(HALF_PI_Q30 % 64'(LOOP_SAMPLES));
	localparam logic [LRCP_W-1:0] LRCP = LRCP_W'(((64'd1 << LSH) + 64'(LOOP_SAMPLES)
	                                     - 64'd1) / 64'(LOOP_SAMPLES));

	localparam logic [Q_W-1:0] L1 = Q_W'(LOOP_SAMPLES);
	localparam logic [Q_W-1:0] L2 = Q_W'(2 * LOOP_SAMPLES);
	localparam logic [Q_W-1:0] L3 = Q_W'(3 * LOOP_SAMPLES);
	localparam logic [T_W-1:0] ONE_Q30 = T_W'(64'd1 << 30);

	localparam logic [31:0] RCP_55 = 32'(((64'd1 << 37) + 64'd54) / 64'd55);
	localparam logic [31:0] RCP_9  = 32'(((64'd1 << 35) + 64'd8) / 64'd9);
	localparam logic [31:0] RCP_21 = 32'(((64'd1 << 36) + 64'd20) / 64'd21);
	localparam logic [31:0] RCP_5  = 32'(((64'd1 << 34) + 64'd4) / 64'd5);
	localparam logic [31:0] RCP_3  = 32'(((64'd1 << 33) + 64'd2) / 64'd3);

	// divisors 110, 72, 42, 20, 6 as a power of two times an odd factor
	function automatic int step_pre(input int k);
		case (k)
			1:       return 3;
			3:       return 2;
			default: return 1;
		endcase
	endfunction

	function automatic int step_sh(input int k);
		case (k)
			0:       return 37;
			1:       return 35;
			2:       return 36;
			3:       return 34;
			default: return 33;
		endcase
	endfunction

	function automatic logic [31:0] step_rcp(input int k);
		case (k)
			0:       return RCP_55;
			1:       return RCP_9;
			2:       return RCP_21;
			3:       return RCP_5;
			default: return RCP_3;
		endcase
	endfunction

	logic [Q_W-1:0]   q;
	logic [1:0]       quad;
	logic [Q_W-1:0]   r_base;
	logic [R_W-1:0]   r_fold;

	logic [R_W-1:0]   r_s1;
	logic [1:0]       quad_s1;
	logic [X_W-1:0]   hi_s2;
	logic [Y_W-1:0]   y_s2;
	logic [1:0]       quad_s2;
	logic [LP_W-1:0]  lprod;
	logic [X_W-1:0]   hi_s3;
	logic [R_W-1:0]   qlo_s3;
	logic [1:0]       quad_s3;
	logic [X_W-1:0]   x_s4;
	logic [1:0]       quad_s4;
	logic [63:0]      xsq;
	logic [X_W-1:0]   x_s5;
	logic [X2_W-1:0]  x2_s5;
	logic [1:0]       quad_s5;

	logic [X2_W-1:0]  m_sa    [NSTEP];
	logic [X_W-1:0]   x_sa    [NSTEP];
	logic [X2_W-1:0]  x2_sa   [NSTEP];
	logic [1:0]       quad_sa [NSTEP];
	logic [T_W-1:0]   t_sb    [NSTEP];
	logic [X_W-1:0]   x_sb    [NSTEP];
	logic [X2_W-1:0]  x2_sb   [NSTEP];
	logic [1:0]       quad_sb [NSTEP];

	logic [63:0]      sprod;
	logic [X_W-1:0]   sv_s16;
	logic [1:0]       quad_s16;
	logic [47:0]      vsum;
	logic [16:0]      vq;
	logic [15:0]      vc;
	logic signed [15:0] sine_s17;

	always_comb begin
		q = {phase, 2'b00};
		if (q >= L3) begin
			quad   = 2'd3;
			r_base = q - L3;
		end else if (q >= L2) begin
			quad   = 2'd2;
			r_base = q - L2;
		end else if (q >= L1) begin
			quad   = 2'd1;
			r_base = q - L1;
		end else begin
			quad   = 2'd0;
			r_base = q;
		end
		if (quad[0]) begin
			r_fold = R_W'(L1 - r_base);
		end else begin
			r_fold = R_W'(r_base);
		end
	end

	assign lprod = LP_W'(y_s2) * LP_W'(LRCP);
	assign xsq   = 64'(x_s4) * 64'(x_s4);

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1     <= r_fold;
			quad_s1  <= quad;
			hi_s2    <= X_W'(X_W'(r_s1) * HQ);
			y_s2     <= Y_W'(Y_W'(r_s1) * Y_W'(HR));
			quad_s2  <= quad_s1;
			hi_s3    <= hi_s2;
			qlo_s3   <= R_W'(lprod >> LSH);
			quad_s3  <= quad_s2;
			x_s4     <= hi_s3 + X_W'(qlo_s3);
			quad_s4  <= quad_s3;
			x_s5     <= x_s4;
			x2_s5    <= X2_W'(xsq >> 30);
			quad_s5  <= quad_s4;
		end
	end

	for (genvar k = 0; k < NSTEP; k++) begin : g_step
		localparam int          PRE = step_pre(k);
		localparam int          SH  = step_sh(k);
		localparam logic [31:0] RCP = step_rcp(k);

		logic [X2_W-1:0] x2_in;
		logic [X_W-1:0]  x_in;
		logic [T_W-1:0]  t_in;
		logic [1:0]      quad_in;
		logic [63:0]     mprod;
		logic [X_W-1:0]  yv;
		logic [63:0]     dprod;

		if (k == 0) begin : g_first
			assign x2_in   = x2_s5;
			assign x_in    = x_s5;
			assign t_in    = ONE_Q30;
			assign quad_in = quad_s5;
		end else begin : g_next
			assign x2_in   = x2_sb[k-1];
			assign x_in    = x_sb[k-1];
			assign t_in    = t_sb[k-1];
			assign quad_in = quad_sb[k-1];
		end

		assign mprod = 64'(x2_in) * 64'(t_in);
		assign yv    = X_W'(m_sa[k] >> PRE);
		assign dprod = 64'(yv) * 64'(RCP);

		always_ff @(posedge clk) begin
			if (en) begin
				m_sa[k]    <= X2_W'(mprod >> 30);
				x_sa[k]    <= x_in;
				x2_sa[k]   <= x2_in;
				quad_sa[k] <= quad_in;
				t_sb[k]    <= ONE_Q30 - T_W'(dprod >> SH);
				x_sb[k]    <= x_sa[k];
				x2_sb[k]   <= x2_sa[k];
				quad_sb[k] <= quad_sa[k];
			end
		end
	end

	assign sprod = 64'(x_sb[NSTEP-1]) * 64'(t_sb[NSTEP-1]);
	assign vsum  = 48'(sv_s16) * 48'd32767 + (48'd1 << 29);
	assign vq    = 17'(vsum >> 30);
	assign vc    = (vq > 17'd32767) ? 16'd32767 : vq[15:0];

	always_ff @(posedge clk) begin
		if (en) begin
			sv_s16   <= X_W'(sprod >> 30);
			quad_s16 <= quad_sb[NSTEP-1];
			sine_s17 <= quad_s16[1] ? $signed(~vc + 16'd1) : $signed(vc);
		end
	end

	assign sine = sine_s17;

endmodule

// ===== src/dtmf_back.sv =====
// ----------------------------------------------------------------------------
// dtmf_back
// Sample back end: pops queued ticks, runs row and column sine lanes, mixes
// with the gains, saturates to 16 bits, encodes A-law or mu-law and holds the
// result in the output register.
// ----------------------------------------------------------------------------
module dtmf_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	input  dtmf_pkg::job_t             q_data,
	output logic                       q_pop,
	input  logic                       law_select,
	input  logic [dtmf_pkg::AMP_W-1:0] row_amplitude,
	input  logic [dtmf_pkg::AMP_W-1:0] col_amplitude,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [7:0]                 law_byte,
	output logic                       tone_on
);
	import dtmf_pkg::*;

	function automatic logic [7:0] alaw_enc(input logic [15:0] s);
		logic [7:0]  mask;
		logic [15:0] mag;
		logic [11:0] m;
		logic [2:0]  seg;
		logic [3:0]  mant;
		mask = s[15] ? 8'h55 : 8'hD5;
		mag  = s[15] ? ~s : s;
		m    = mag[14:3];
		seg  = 3'd0;
		for (int i = 0; i < 7; i++) begin
			if ((m >> (5 + i)) != 12'd0) begin
				seg = 3'(i + 1);
			end
		end
		mant = (seg < 3'd2) ? m[4:1] : 4'(m >> seg);
		return {1'b0, seg, mant} ^ mask;
	endfunction

	function automatic logic [7:0] ulaw_enc(input logic [15:0] s);
		logic [7:0]  mask;
		logic [16:0] nv;
		logic [13:0] m;
		logic [3:0]  seg;
		mask = s[15] ? 8'h7F : 8'hFF;
		nv   = ~{s[15], s} + 17'd1;
		m    = s[15] ? 14'((nv + 17'd3) >> 2) : s[15:2];
		if (m > 14'd8159) begin
			m = 14'd8159;
		end
		m   = m + 14'd33;
		seg = 4'd0;
		for (int i = 0; i < 8; i++) begin
			if ((m >> (6 + i)) != 14'd0) begin
				seg = 4'(i + 1);
			end
		end
		if (seg[3]) begin
			return 8'h7F ^ mask;
		end
		return {1'b0, seg[2:0], 4'(m >> (seg + 4'd1))} ^ mask;
	endfunction

	logic               en;
	logic               pipe_vld_q [PIPE_LAT];
	logic               pipe_act_q [PIPE_LAT];
	logic signed [15:0] row_sine;
	logic signed [15:0] col_sine;

	logic signed [31:0] prod_r_s18;
	logic signed [31:0] prod_c_s18;
	logic signed [31:0] acc_s19;
	logic [16:0]        nmag;
	logic [16:0]        pmag;
	logic [15:0]        lin;
	logic [15:0]        lin_s20;

	logic               out_vld_q;
	logic [7:0]         law_byte_q;
	logic               tone_on_q;

	assign en    = !out_vld_q || out_ready;
	assign q_pop = en && q_valid;

	dtmf_sine u_row_sine (
		.clk   (clk),
		.en    (en),
		.phase (q_data.row_phase),
		.sine  (row_sine)
	);

	dtmf_sine u_col_sine (
		.clk   (clk),
		.en    (en),
		.phase (q_data.col_phase),
		.sine  (col_sine)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PIPE_LAT; i++) begin
				pipe_vld_q[i] <= 1'b0;
			end
			out_vld_q <= 1'b0;
		end else if (en) begin
			pipe_vld_q[0] <= q_valid;
			for (int i = 1; i < PIPE_LAT; i++) begin
				pipe_vld_q[i] <= pipe_vld_q[i-1];
			end
			out_vld_q <= pipe_vld_q[PIPE_LAT-1];
		end
	end

	always_comb begin
		nmag = 17'(32'(-acc_s19) >> 15);
		pmag = 17'(acc_s19 >>> 15);
		if (acc_s19[31]) begin
			lin = (nmag > 17'd32768) ? 16'h8000 : 16'(~nmag + 17'd1);
		end else begin
			lin = (pmag > 17'd32767) ? 16'h7FFF : pmag[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_act_q[0] <= q_data.active;
			for (int i = 1; i < PIPE_LAT; i++) begin
				pipe_act_q[i] <= pipe_act_q[i-1];
			end
			prod_r_s18 <= 32'(row_sine) * $signed({17'd0, row_amplitude});
			prod_c_s18 <= 32'(col_sine) * $signed({17'd0, col_amplitude});
			acc_s19    <= prod_r_s18 + prod_c_s18;
			lin_s20    <= lin;
			tone_on_q  <= pipe_act_q[PIPE_LAT-1];
			if (!pipe_act_q[PIPE_LAT-1]) begin
				law_byte_q <= 8'd0;
			end else if (law_select) begin
				law_byte_q <= alaw_enc(lin_s20);
			end else begin
				law_byte_q <= ulaw_enc(lin_s20);
			end
		end
	end

	assign out_valid = out_vld_q;
	assign law_byte  = law_byte_q;
	assign tone_on   = tone_on_q;

endmodule

// ===== src/dtmf_tone_generator_core.sv =====
// ----------------------------------------------------------------------------
// dtmf_tone_generator_core
// DTMF tone generator with G.711 A-law / mu-law output, one byte per tick.
//
// Requests enter on the s_axis channel: tuser carries the request kind (tick,
// start, stop), tdata the keypad character of a start request. Only ticks
// produce a result on m_axis: tdata is the companded byte, tuser is set when
// a tone sample is carried (tone off gives byte zero with tuser clear).
// Gains and the companding law are written on the cfg channel, which is
// always ready; write it only while no tick is in flight.
// Throughput is one request per cycle while the request queue is not full.
// A tick is registered into the request queue, then passes 17 stages of the
// two sine lanes (five Horner steps of two multiplies each), then mix,
// saturate and the encoded output register before it reaches m_axis.
// When m_axis stalls, the whole sample pipeline holds; the four-entry request
// queue keeps taking ticks until it fills, then s_axis_tready drops. Start
// and stop requests are taken whenever the queue is not full.
// Reset turns the tone off, clears both phases and loads A-law, row gain 8224
// and column gain 5177.
// ----------------------------------------------------------------------------
module dtmf_tone_generator_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [7:0]                     s_axis_tdata,   // [7:0] key_char
	input  logic [1:0]                     s_axis_tuser,   // [1:0] req_type
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [7:0]                     m_axis_tdata,   // [7:0] law_byte
	output logic                           m_axis_tuser,   // [0] tone_on
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dtmf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dtmf_pkg::AMP_W-1:0]     cfg_data
);
	import dtmf_pkg::*;

	logic             law_q;
	logic [AMP_W-1:0] row_amp_q;
	logic [AMP_W-1:0] col_amp_q;

	logic             q_push;
	logic             q_full;
	logic             q_pop;
	logic             q_valid;
	job_t             q_in;
	job_t             q_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			law_q     <= 1'b1;
			row_amp_q <= ROW_AMP_RESET;
			col_amp_q <= COL_AMP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_LAW:     law_q     <= cfg_data[0];
				CFG_ROW_AMP: row_amp_q <= cfg_data;
				CFG_COL_AMP: col_amp_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	dtmf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_axis_tvalid),
		.req_ready (s_axis_tready),
		.req_type  (s_axis_tuser),
		.key_char  (s_axis_tdata),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_in)
	);

	dtmf_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_data  (q_out)
	);

	dtmf_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_data        (q_out),
		.q_pop         (q_pop),
		.law_select    (law_q),
		.row_amplitude (row_amp_q),
		.col_amplitude (col_amp_q),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.law_byte      (m_axis_tdata),
		.tone_on       (m_axis_tuser)
	);

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("tick queued into a full request queue");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("back end popped an empty request queue");

	a_silent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 8'd0))
		else $error("tone-off sample carries a nonzero byte");

endmodule

// ===== tb/sv/dtmf_tone_checker.sv =====
// ----------------------------------------------------------------------------
// dtmf_tone_checker
// Watches the request, sample and register channels of the DTMF tone
// generator. Predicts each companded sample byte from its own copy of the
// tone state and gains, and compares every sample byte taken on m_axis
// against the oldest prediction.
// ----------------------------------------------------------------------------
module dtmf_tone_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	input  logic [7:0]                     s_axis_tdata,   // [7:0] key_char
	input  logic [1:0]                     s_axis_tuser,   // [1:0] req_type
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic [7:0]                     m_axis_tdata,   // [7:0] law_byte
	input  logic                           m_axis_tuser,   // [0] tone_on
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [dtmf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dtmf_pkg::AMP_W-1:0]     cfg_data,
	output int                             mismatch_count,
	output int                             outstanding
);
	import dtmf_pkg::*;

	typedef struct packed {
		logic [7:0] law_byte;
		logic       tone_on;
	} tone_sample_t;

	tone_sample_t expected_samples[$];
	tone_sample_t want;

	logic        law_alaw;
	int unsigned row_gain;
	int unsigned col_gain;
	logic        tone_active;
	logic [3:0]  tone_key;
	int unsigned row_ph;
	int unsigned col_ph;

	longint          acc;
	longint unsigned mag;
	int              lin;
	int              key_pos;

	function automatic int unsigned row_hz(input logic [1:0] sel);
		case (sel)
			2'd0: return 697;
			2'd1: return 770;
			2'd2: return 852;
			default: return 941;
		endcase
	endfunction

	function automatic int unsigned col_hz(input logic [1:0] sel);
		case (sel)
			2'd0: return 1209;
			2'd1: return 1336;
			2'd2: return 1477;
			default: return 1633;
		endcase
	endfunction

	function automatic int key_position(input logic [7:0] c);
		case (c)
			"1": return 0;
			"2": return 1;
			"3": return 2;
			"A", "a": return 3;
			"4": return 4;
			"5": return 5;
			"6": return 6;
			"B", "b": return 7;
			"7": return 8;
			"8": return 9;
			"9": return 10;
			"C", "c": return 11;
			"*": return 12;
			"0": return 13;
			"#": return 14;
			"D", "d": return 15;
			default: return -1;
		endcase
	endfunction

	// Q1.15 sine of phase p over one loop, polynomial in Q2.30
	function automatic int sine_q15(input int unsigned p);
		longint unsigned pp, q, quad, r, x, x2, t, s, v, div_k;
		int step;
		pp = p;
		q = (pp % LOOP_SAMPLES) * 4;
		quad = q / LOOP_SAMPLES;
		r = q % LOOP_SAMPLES;
		if (quad[0])
			r = LOOP_SAMPLES - r;
		x = (64'd1686629713 * r) / LOOP_SAMPLES;
		x2 = (x * x) >> 30;
		t = 64'd1 << 30;
		for (step = 0; step < 5; step++) begin
			case (step)
				0: div_k = 110;
				1: div_k = 72;
				2: div_k = 42;
				3: div_k = 20;
				default: div_k = 6;
			endcase
			t = (64'd1 << 30) - ((x2 * t) >> 30) / div_k;
		end
		s = (x * t) >> 30;
		v = (s * 32767 + (64'd1 << 29)) >> 30;
		if (v > 32767)
			v = 32767;
		return (quad >= 2) ? -int'(v) : int'(v);
	endfunction

	function automatic int unsigned segment_of(input int unsigned v, input int unsigned first_end);
		int unsigned seg, seg_end;
		seg = 0;
		seg_end = first_end;
		while (seg < 8 && v > seg_end) begin
			seg++;
			seg_end = (seg_end << 1) | 1;
		end
		return seg;
	endfunction

	function automatic logic [7:0] alaw_encode(input int s);
		logic [7:0]  mask;
		int unsigned m, seg, a;
		if (s >= 0) begin
			mask = 8'hD5;
			m = s >> 3;
		end else begin
			mask = 8'h55;
			m = (-(s + 1)) >> 3;
		end
		seg = segment_of(m, 'h1F);
		if (seg >= 8)
			return 8'h7F ^ mask;
		a = seg << 4;
		if (seg < 2)
			a = a | ((m >> 1) & 'hF);
		else
			a = a | ((m >> seg) & 'hF);
		return a[7:0] ^ mask;
	endfunction

	function automatic logic [7:0] mulaw_encode(input int s);
		logic [7:0]  mask;
		int unsigned m, seg, u;
		if (s < 0) begin
			mask = 8'h7F;
			m = (-s + 3) >> 2;
		end else begin
			mask = 8'hFF;
			m = s >> 2;
		end
		if (m > 8159)
			m = 8159;
		m = m + 33;
		seg = segment_of(m, 'h3F);
		if (seg >= 8)
			return 8'h7F ^ mask;
		u = (seg << 4) | ((m >> (seg + 1)) & 'hF);
		return u[7:0] ^ mask;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int wanted);
		$display("[%0t] sample check: %s got %0d, wanted %0d", $time, what, got, wanted);
		mismatch_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			law_alaw = 1'b1;
			row_gain = 32'(ROW_AMP_RESET);
			col_gain = 32'(COL_AMP_RESET);
			tone_active = 1'b0;
			tone_key = 4'd0;
			row_ph = 0;
			col_ph = 0;
			mismatch_count = 0;
			expected_samples.delete();
			outstanding <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_samples.size() == 0) begin
					report_mismatch("unrequested sample byte", int'(m_axis_tdata), -1);
				end else begin
					want = expected_samples.pop_front();
					if (m_axis_tdata !== want.law_byte)
						report_mismatch("law_byte", int'(m_axis_tdata), int'(want.law_byte));
					if (m_axis_tuser !== want.tone_on)
						report_mismatch("tone_on", int'(m_axis_tuser), int'(want.tone_on));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_LAW: law_alaw = cfg_data[0];
					CFG_ROW_AMP: row_gain = 32'(cfg_data);
					CFG_COL_AMP: col_gain = 32'(cfg_data);
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				case (s_axis_tuser)
					REQ_START: begin
						key_pos = key_position(s_axis_tdata);
						if (key_pos >= 0) begin
							tone_key = key_pos[3:0];
							tone_active = 1'b1;
						end
						row_ph = 0;
						col_ph = 0;
					end
					REQ_STOP: begin
						tone_active = 1'b0;
					end
					REQ_TICK: begin
						if (!tone_active) begin
							want.law_byte = 8'h00;
							want.tone_on = 1'b0;
						end else begin
							acc = longint'(sine_q15(row_ph)) * longint'(row_gain)
							    + longint'(sine_q15(col_ph)) * longint'(col_gain);
							if (acc < 0) begin
								mag = -acc;
								mag = mag >> 15;
								lin = (mag > 32768) ? -32768 : -int'(mag);
							end else begin
								mag = acc;
								mag = mag >> 15;
								lin = (mag > 32767) ? 32767 : int'(mag);
							end
							want.law_byte = law_alaw ? alaw_encode(lin) : mulaw_encode(lin);
							want.tone_on = 1'b1;
							row_ph = (row_ph + row_hz(tone_key[3:2])) % LOOP_SAMPLES;
							col_ph = (col_ph + col_hz(tone_key[1:0])) % LOOP_SAMPLES;
						end
						expected_samples.push_back(want);
					end
					default: ;
				endcase
			end
			outstanding <= expected_samples.size();
		end
	end

endmodule

// ===== tb/sv/dtmf_tone_generator_core_tb.sv =====
// ----------------------------------------------------------------------------
// dtmf_tone_generator_core_tb
// Drives start, stop and sample requests into the DTMF tone generator under
// several gain and companding settings, with random gaps on the request side
// and random stalls on the sample side. A checker beside the block predicts
// and compares every sample byte; this module gives the verdict.
// ----------------------------------------------------------------------------
module dtmf_tone_generator_core_tb;
	import dtmf_pkg::*;

	localparam logic [1:0]           REQ_UNUSED    = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED    = 2'd3;
	localparam int                   SETTLE_CYCLES = PIPE_LAT + QUEUE_DEPTH + 8;
	localparam int                   CYCLE_LIMIT   = 300000;

	logic                 clk;
	logic                 arst_n        = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [7:0]           s_axis_tdata  = 8'd0;
	logic [1:0]           s_axis_tuser  = 2'd0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [7:0]           m_axis_tdata;
	logic                 m_axis_tuser;
	logic                 cfg_valid     = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index     = '0;
	logic [AMP_W-1:0]     cfg_data      = '0;

	logic idle_enable = 1'b1;
	int   mismatch_count;
	int   outstanding;
	int   cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	dtmf_tone_generator_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	dtmf_tone_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tuser   (s_axis_tuser),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.m_axis_tuser   (m_axis_tuser),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	always @(posedge clk) begin
		m_axis_tready <= idle_enable ? ($urandom_range(99) >= 20) : 1'b1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic logic [7:0] keypad_char();
		case ($urandom_range(19))
			0: return "1";
			1: return "2";
			2: return "3";
			3: return "A";
			4: return "4";
			5: return "5";
			6: return "6";
			7: return "B";
			8: return "7";
			9: return "8";
			10: return "9";
			11: return "C";
			12: return "*";
			13: return "0";
			14: return "#";
			15: return "D";
			16: return "a";
			17: return "b";
			18: return "c";
			default: return "d";
		endcase
	endfunction

	task automatic send_request(input logic [1:0] kind, input logic [7:0] key);
		while (idle_enable && $urandom_range(99) < 20) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= key;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [AMP_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Drain, let the pipe settle, then load all three registers
	task automatic configure(input logic law, input logic [AMP_W-1:0] row_gain,
	                         input logic [AMP_W-1:0] col_gain);
		logic [AMP_W-2:0] law_pad;
		law_pad = (AMP_W - 1)'($urandom_range(0, 16383));
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_register(CFG_LAW, {law_pad, law});
		write_register(CFG_ROW_AMP, row_gain);
		write_register(CFG_COL_AMP, col_gain);
	endtask

	task automatic run_random(input int count);
		int sent;
		int burst;
		int pick;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(99) < 3)
				wait_drained();
			pick = $urandom_range(99);
			if (pick < 65) begin
				send_request(REQ_START, keypad_char());
				burst = $urandom_range(1, 24);
				sent += 1 + burst;
				repeat (burst) begin
					pick = $urandom_range(99);
					if (pick < 90)
						send_request(REQ_TICK, 8'($urandom_range(255)));
					else if (pick < 95)
						send_request(REQ_START, 8'($urandom_range(255)));
					else
						send_request(REQ_STOP, 8'($urandom_range(255)));
				end
			end else if (pick < 77) begin
				send_request(REQ_TICK, 8'($urandom_range(255)));
				sent++;
			end else if (pick < 85) begin
				send_request(REQ_START, 8'($urandom_range(255)));
				sent++;
			end else if (pick < 93) begin
				send_request(REQ_STOP, 8'($urandom_range(255)));
				sent++;
			end else begin
				send_request(REQ_UNUSED, 8'($urandom_range(255)));
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(REQ_TICK, 8'h00);
		send_request(REQ_START, 8'h00);
		send_request(REQ_TICK, 8'hFF);
		send_request(REQ_START, "5");
		send_request(REQ_TICK, 8'h00);
		send_request(REQ_TICK, 8'h00);
		send_request(REQ_TICK, 8'h00);
		send_request(REQ_START, 8'hFF);
		send_request(REQ_TICK, 8'h00);
		send_request(REQ_TICK, 8'h00);
		send_request(REQ_UNUSED, 8'hA5);
		send_request(REQ_TICK, 8'h00);
		send_request(REQ_START, "d");
		send_request(REQ_TICK, 8'h00);
		send_request(REQ_TICK, 8'h00);
		send_request(REQ_START, "#");
		send_request(REQ_TICK, 8'h00);
		send_request(REQ_STOP, 8'h5A);
		send_request(REQ_TICK, 8'h00);
		send_request(REQ_UNUSED, 8'h00);
		send_request(REQ_START, "*");
		send_request(REQ_TICK, 8'h00);
		send_request(REQ_START, "A");
		send_request(REQ_TICK, 8'hFF);
		run_random(20);

		configure(1'b0, ROW_AMP_RESET, COL_AMP_RESET);
		run_random(50);
		configure(1'b1, 15'h7FFF, 15'h7FFF);
		run_random(50);
		configure(1'b0, 15'h7FFF, 15'h7FFF);
		run_random(50);
		configure(1'b1, 15'h0000, 15'h0000);
		run_random(30);
		configure(1'b0, 15'h0000, 15'h7FFF);
		write_register(CFG_UNUSED, AMP_W'($urandom_range(0, 32767)));
		run_random(40);
		configure(1'($urandom_range(1)), AMP_W'($urandom_range(0, 32767)),
		          AMP_W'($urandom_range(0, 32767)));
		idle_enable <= 1'b0;
		run_random(80);
		wait_drained();
		idle_enable <= 1'b1;
		configure(1'b1, ROW_AMP_RESET, COL_AMP_RESET);
		run_random(30);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && outstanding == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
